@@ sv/hx64_pkg.sv @@
// Shared types, codes and helpers for the hex to base64 stream encoder.
// Depends on nothing; every other file imports it.
package hx64_pkg;

  // Field widths of the two channels.
  localparam int HEX_W = 8;
  localparam int B64_W = 7;

  // Depth of the job queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Job kinds handed from the front to the back.
  localparam logic [1:0] JOB_ERR  = 2'd0;  // bad digit: one error result
  localparam logic [1:0] JOB_PAIR = 2'd1;  // full 12-bit group: two symbols
  localparam logic [1:0] JOB_ONE  = 2'd2;  // one leftover nibble: symbol and "="
  localparam logic [1:0] JOB_TWO  = 2'd3;  // two leftover nibbles: two symbols and "=="

  // ASCII codes used by the encoder.
  localparam logic [HEX_W-1:0] ASC_0   = 8'd48;
  localparam logic [HEX_W-1:0] ASC_9   = 8'd57;
  localparam logic [HEX_W-1:0] ASC_A   = 8'd65;
  localparam logic [HEX_W-1:0] ASC_F   = 8'd70;
  localparam logic [HEX_W-1:0] ASC_A10 = 8'd55;  // 'A' minus ten
  localparam logic [B64_W-1:0] ASC_PAD = 7'd61;  // '='

  // One job: the kind, up to twelve data bits and the message-end flag.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] data;
    logic        last;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  // Map a six-bit value to its base64 character.
  function automatic logic [B64_W-1:0] b64_symbol(input logic [5:0] v);
    logic [B64_W-1:0] ve;
    ve = {1'b0, v};
    if (v <= 6'd25) begin
      b64_symbol = ve + 7'd65;
    end else if (v <= 6'd51) begin
      b64_symbol = ve + 7'd71;
    end else if (v <= 6'd61) begin
      b64_symbol = ve - 7'd4;
    end else if (v == 6'd62) begin
      b64_symbol = 7'd43;
    end else begin
      b64_symbol = 7'd47;
    end
  endfunction

  // Index of the last result that a job of the given kind produces.
  function automatic logic [1:0] job_last_idx(input logic [1:0] kind);
    unique case (kind)
      JOB_ERR:  job_last_idx = 2'd0;
      JOB_PAIR: job_last_idx = 2'd1;
      JOB_ONE:  job_last_idx = 2'd1;
      default:  job_last_idx = 2'd3;
    endcase
  endfunction

endpackage

@@ sv/hx64_if.sv @@
// Valid/ready channel interfaces for the hex digit input and the base64 output.
// Depends on hx64_pkg for the field widths.
interface hx64_in_if;
  import hx64_pkg::*;
  logic             valid;
  logic             ready;
  logic [HEX_W-1:0] hex_char;
  logic             end_of_message;

  modport source(output valid, output hex_char, output end_of_message, input ready);
  modport sink(input valid, input hex_char, input end_of_message, output ready);
endinterface

interface hx64_out_if;
  import hx64_pkg::*;
  logic             valid;
  logic             ready;
  logic [B64_W-1:0] b64_char;
  logic             final_char;
  logic             bad_digit;

  modport source(output valid, output b64_char, output final_char, output bad_digit,
                 input ready);
  modport sink(input valid, input b64_char, input final_char, input bad_digit,
               output ready);
endinterface

@@ sv/hex_to_base64_stream_core.sv @@
// Hex to base64 stream encoder, top level: front end, job queue and back end.
// Depends on hx64_pkg, hx64_if, hx64_front, hx64_queue and hx64_back.
//
// One ASCII hex digit ('0'-'9', 'A'-'F') enters per request, with a flag on
// the last digit of a message; base64 characters leave one per cycle while
// the sink is ready. The input takes a new digit every cycle while the
// four-entry job queue has room, also for digits that only fill the pending
// nibbles. Every third digit makes two characters, a message end with leftover
// bits makes two or four (padding included), and a bad digit makes one error
// result that closes the message. The output port sets the sustained rate at
// one character per cycle: full groups stream at one digit per cycle, since
// three digits give two characters, while messages of one or two digits
// make two characters per digit. The first character of a digit passes
// through the job queue and the output register before it is presented.
module hex_to_base64_stream_core (
  input  logic       clk,
  input  logic       rst_n,
  hx64_in_if.sink    in_ch,
  hx64_out_if.source out_ch
);
  import hx64_pkg::*;

  logic    push, pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  // Digit decode and pending-nibble tracking.
  hx64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Jobs waiting for the output sequencer.
  hx64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Character generation and output register.
  hx64_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ sv/hx64_front.sv @@
// Front end: accepts hex digits, decodes them and tracks the pending nibbles.
// Depends on hx64_pkg and hx64_in_if; pushes jobs toward hx64_queue.
module hx64_front (
  input  logic              clk,
  input  logic              rst_n,
  hx64_in_if.sink           in_ch,
  input  hx64_pkg::q_stat_t q_stat,
  output logic              push,
  output hx64_pkg::job_t    push_job
);
  import hx64_pkg::*;

  logic [7:0] pend_r, pend_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       accept;
  logic       is_dec, is_hex;
  logic [3:0] nib;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the incoming character and extract its nibble.
  always_comb begin
    logic [HEX_W-1:0] diff;
    diff   = '0;
    is_dec = (in_ch.hex_char >= ASC_0) && (in_ch.hex_char <= ASC_9);
    is_hex = (in_ch.hex_char >= ASC_A) && (in_ch.hex_char <= ASC_F);
    if (is_dec) begin
      diff = in_ch.hex_char - ASC_0;
    end else begin
      diff = in_ch.hex_char - ASC_A10;
    end
    nib = diff[3:0];
  end

  // Decide the job for this digit and the next pending state.
  always_comb begin
    pend_nxt      = pend_r;
    phase_nxt     = phase_r;
    push          = 1'b0;
    push_job.kind = JOB_ERR;
    push_job.data = '0;
    push_job.last = 1'b1;
    if (accept) begin
      if (!(is_dec || is_hex)) begin
        // A bad digit ends the message with an error and clears the state.
        push      = 1'b1;
        pend_nxt  = '0;
        phase_nxt = '0;
      end else if (phase_r == 2'd2) begin
        push          = 1'b1;
        push_job.kind = JOB_PAIR;
        push_job.data = {pend_r, nib};
        push_job.last = in_ch.end_of_message;
        pend_nxt      = '0;
        phase_nxt     = '0;
      end else if (phase_r == 2'd1) begin
        if (in_ch.end_of_message) begin
          push          = 1'b1;
          push_job.kind = JOB_TWO;
          push_job.data = {4'd0, pend_r[3:0], nib};
          pend_nxt      = '0;
          phase_nxt     = '0;
        end else begin
          pend_nxt  = {pend_r[3:0], nib};
          phase_nxt = 2'd2;
        end
      end else begin
        // Phase zero, or the unreachable phase three treated alike.
        if (in_ch.end_of_message) begin
          push          = 1'b1;
          push_job.kind = JOB_ONE;
          push_job.data = {8'd0, nib};
          pend_nxt      = '0;
          phase_nxt     = '0;
        end else begin
          pend_nxt  = {4'd0, nib};
          phase_nxt = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      phase_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ sv/hx64_queue.sv @@
// Short job queue that decouples the front end from the output sequencer.
// Depends on hx64_pkg for job_t, q_stat_t and the queue depth.
module hx64_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hx64_pkg::job_t     push_job,
  input  logic               pop,
  output hx64_pkg::job_t     head_job,
  output hx64_pkg::q_stat_t  q_stat
);
  import hx64_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full     = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.nonempty = (cnt_r != '0);
  assign head_job        = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Job storage; entries need no reset since the count guards them.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ sv/hx64_back.sv @@
// Back end: turns each queued job into base64 characters, one per ready cycle.
// Depends on hx64_pkg and hx64_out_if; reads the head of hx64_queue.
module hx64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hx64_pkg::job_t    head_job,
  input  hx64_pkg::q_stat_t q_stat,
  output logic              pop,
  hx64_out_if.source        out_ch
);
  import hx64_pkg::*;

  logic [1:0]       idx_r, idx_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [B64_W-1:0] ochar_r;
  logic             ofinal_r, obad_r;
  logic             load;
  logic [B64_W-1:0] ch;
  logic             fin, bad;

  assign out_ch.valid      = ovalid_r;
  assign out_ch.b64_char   = ochar_r;
  assign out_ch.final_char = ofinal_r;
  assign out_ch.bad_digit  = obad_r;

  // The output register takes a new character whenever it is empty or draining.
  assign load = q_stat.nonempty && (!ovalid_r || out_ch.ready);
  assign pop  = load && (idx_r == job_last_idx(head_job.kind));

  // Character for the current position within the head job.
  always_comb begin
    ch  = '0;
    fin = 1'b0;
    bad = 1'b0;
    unique case (head_job.kind)
      JOB_ERR: begin
        fin = 1'b1;
        bad = 1'b1;
      end
      JOB_PAIR: begin
        if (idx_r == 2'd0) begin
          ch = b64_symbol(head_job.data[11:6]);
        end else begin
          ch  = b64_symbol(head_job.data[5:0]);
          fin = head_job.last;
        end
      end
      JOB_ONE: begin
        if (idx_r == 2'd0) begin
          ch = b64_symbol({head_job.data[3:0], 2'b00});
        end else begin
          ch  = ASC_PAD;
          fin = 1'b1;
        end
      end
      default: begin
        case (idx_r)
          2'd0:    ch = b64_symbol(head_job.data[7:2]);
          2'd1:    ch = b64_symbol({head_job.data[1:0], 4'd0});
          2'd2:    ch = ASC_PAD;
          default: begin
            ch  = ASC_PAD;
            fin = 1'b1;
          end
        endcase
      end
    endcase
  end

  // Position counter and output valid.
  always_comb begin
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = pop ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Output payload, held while the sink stalls.
  always_ff @(posedge clk) begin
    if (load) begin
      ochar_r  <= ch;
      ofinal_r <= fin;
      obad_r   <= bad;
    end
  end

endmodule

@@ sv/hx64_checker.sv @@
// Port-level checks for the hex to base64 stream encoder, bound to the top.
// Depends on hx64_pkg for field widths and codes.
module hx64_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [hx64_pkg::B64_W-1:0] out_b64_char,
  input logic                     out_final_char,
  input logic                     out_bad_digit
);
  import hx64_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_b64_char)
      && $stable(out_final_char) && $stable(out_bad_digit))
    else $error("stalled result changed");

  // The error result closes the message and carries a zero character.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_digit |-> out_final_char && (out_b64_char == '0))
    else $error("malformed error result");

  // Ordinary results are printable characters.
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_digit |-> (out_b64_char != '0))
    else $error("zero character without error flag");

  // Nothing is shown right after reset, and the input is then open.
  a_reset_clean: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("result valid or input closed right after reset");

endmodule

bind hex_to_base64_stream_core hx64_checker u_hx64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_b64_char   (out_ch.b64_char),
  .out_final_char (out_ch.final_char),
  .out_bad_digit  (out_ch.bad_digit)
);

@@ tb/hx64_char_checker.sv @@
// Watches both channels of the hex to base64 encoder, predicts every base64
// character from the accepted digit requests and compares it on arrival.
// Depends on hx64_pkg for widths and ASCII codes, and on hx64_if.
module hx64_char_checker (
  input  logic clk,
  input  logic rst_n,
  hx64_in_if   in_ch,
  hx64_out_if  out_ch,
  output int   fail_count,
  output int   outstanding,
  output int   checked
);
  import hx64_pkg::*;

  // One expected character with its flags.
  typedef struct packed {
    logic [B64_W-1:0] ch;
    logic             fin;
    logic             bad;
  } b64_result_t;

  // Encoder state as the predictor sees it.
  logic [7:0]  held_nibbles;
  logic [1:0]  held_count;
  b64_result_t expected_chars[$];
  int          fails;
  int          seen;

  // Base64 alphabet lookup for one six-bit group.
  function automatic logic [B64_W-1:0] sextet_char(input logic [5:0] v);
    logic [7:0] code;
    if (v < 6'd26) begin
      code = "A" + 8'(v);
    end else if (v < 6'd52) begin
      code = "a" + 8'(v) - 8'd26;
    end else if (v < 6'd62) begin
      code = "0" + 8'(v) - 8'd52;
    end else if (v == 6'd62) begin
      code = "+";
    end else begin
      code = "/";
    end
    return code[B64_W-1:0];
  endfunction

  function automatic void push_char(input logic [B64_W-1:0] ch, input logic fin,
                                    input logic bad);
    b64_result_t r;
    r.ch  = ch;
    r.fin = fin;
    r.bad = bad;
    expected_chars.push_back(r);
  endfunction

  // Advance the predicted state by one digit request and queue its characters.
  function automatic void encode_digit(input logic [HEX_W-1:0] c, input logic eom);
    logic [3:0]  nib;
    logic [11:0] grp;
    logic        ok;
    ok  = 1'b1;
    nib = 4'h0;
    if (c >= ASC_0 && c <= ASC_9) begin
      nib = 4'(c - ASC_0);
    end else if (c >= ASC_A && c <= ASC_F) begin
      nib = 4'(c - ASC_A10);
    end else begin
      ok = 1'b0;
    end

    if (!ok) begin
      // A bad code ends the message with a single error character.
      push_char('0, 1'b1, 1'b1);
      held_nibbles = 8'h00;
      held_count   = 2'd0;
    end else if (held_count == 2'd2) begin
      // Third digit completes a 12-bit group; no padding even at the end.
      grp = {held_nibbles, nib};
      push_char(sextet_char(grp[11:6]), 1'b0, 1'b0);
      push_char(sextet_char(grp[5:0]), eom, 1'b0);
      held_nibbles = 8'h00;
      held_count   = 2'd0;
    end else begin
      if (held_count == 2'd1) begin
        held_nibbles = {held_nibbles[3:0], nib};
        held_count   = 2'd2;
      end else begin
        held_nibbles = {4'h0, nib};
        held_count   = 2'd1;
      end
      // At the message end the leftover bits are encoded and padded.
      if (eom) begin
        if (held_count == 2'd1) begin
          push_char(sextet_char({held_nibbles[3:0], 2'b00}), 1'b0, 1'b0);
          push_char(ASC_PAD, 1'b1, 1'b0);
        end else begin
          push_char(sextet_char(held_nibbles[7:2]), 1'b0, 1'b0);
          push_char(sextet_char({held_nibbles[1:0], 4'b0000}), 1'b0, 1'b0);
          push_char(ASC_PAD, 1'b0, 1'b0);
          push_char(ASC_PAD, 1'b1, 1'b0);
        end
        held_nibbles = 8'h00;
        held_count   = 2'd0;
      end
    end
  endfunction

  // Predict on every accepted request, then check every accepted character.
  always @(posedge clk) begin
    b64_result_t want;
    if (!rst_n) begin
      held_nibbles = 8'h00;
      held_count   = 2'd0;
      expected_chars.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_digit(in_ch.hex_char, in_ch.end_of_message);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: b64_char %0d final_char %0d bad_digit %0d",
                 out_ch.b64_char, out_ch.final_char, out_ch.bad_digit);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.b64_char !== want.ch) begin
            $error("b64_char: expected %0d, got %0d", want.ch, out_ch.b64_char);
            fails++;
          end
          if (out_ch.final_char !== want.fin) begin
            $error("final_char: expected %0d, got %0d", want.fin, out_ch.final_char);
            fails++;
          end
          if (out_ch.bad_digit !== want.bad) begin
            $error("bad_digit: expected %0d, got %0d", want.bad, out_ch.bad_digit);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= expected_chars.size();
    checked     <= seen;
  end

  initial begin
    fails        = 0;
    seen         = 0;
    held_nibbles = 8'h00;
    held_count   = 2'd0;
    fail_count   = 0;
    outstanding  = 0;
    checked      = 0;
  end

endmodule

@@ tb/tb_hex_to_base64_stream_core.sv @@
// Top of the hex to base64 encoder testbench: clock, reset, digit requests
// and output back-pressure; the verdict comes from hx64_char_checker.
// Depends on hx64_pkg, hx64_if, hex_to_base64_stream_core and hx64_char_checker.
module tb_hex_to_base64_stream_core;
  import hx64_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int MAX_WAIT     = 13;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   checked;
  int   n_items;
  int   n_msgs;
  int   n_bad;
  logic in_calm;
  logic out_calm;

  hx64_in_if  in_ch();
  hx64_out_if out_ch();

  hex_to_base64_stream_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  hx64_char_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic is_hex(input logic [HEX_W-1:0] c);
    return (c >= ASC_0 && c <= ASC_9) || (c >= ASC_A && c <= ASC_F);
  endfunction

  function automatic logic [HEX_W-1:0] rand_digit();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? ASC_0 + 8'(v) : ASC_A + 8'(v - 10);
  endfunction

  function automatic logic [HEX_W-1:0] rand_bad_code();
    logic [HEX_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_hex(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Offer one digit request after a random gap and hold it until taken.
  // Valid stays high afterwards so back-to-back requests need no toggle.
  task automatic send_req(input logic [HEX_W-1:0] c, input logic eom);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.hex_char       <= c;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (!is_hex(c)) n_bad++;
    if (eom || !is_hex(c)) n_msgs++;
  endtask

  // One message from a string, the last digit flagged.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_req(s[i], i == s.len() - 1);
    end
  endtask

  // Stop offering requests until every predicted character has arrived.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Output side: a random stall before each character, with calm stretches.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    out_calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      stall = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Reset, directed messages, random messages, then the verdict.
  initial begin
    int  kind;
    int  len;
    int  guard;
    logic paused;
    in_ch.valid          <= 1'b0;
    in_ch.hex_char       <= '0;
    in_ch.end_of_message <= 1'b0;
    rst_n                <= 1'b0;
    n_items = 0;
    n_msgs  = 0;
    n_bad   = 0;
    in_calm = 1'b0;
    paused  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full groups at the end, both leftover sizes, digit range
    // edges, and bad codes at every phase and at the byte extremes.
    send_text("000");
    send_text("FFF");
    send_text("F");
    send_text("09");
    send_req("A", 1'b0);
    send_req(":", 1'b0);
    send_req("/", 1'b1);
    send_req("@", 1'b0);
    send_req("G", 1'b1);
    send_req("a", 1'b1);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b1);
    send_req("1", 1'b0);
    send_req("2", 1'b0);
    send_req("f", 1'b1);
    send_text("BCDE");

    // Random: mostly well-formed messages, some cut short by a bad code,
    // some single noise bytes.
    while (n_items < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 99);
      in_calm = ($urandom_range(0, 4) == 0);
      if (kind < 80) begin
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) send_req(rand_digit(), i == len - 1);
      end else if (kind < 90) begin
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) send_req(rand_digit(), 1'b0);
        send_req(rand_bad_code(), 1'($urandom_range(0, 1)));
      end else begin
        send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      if (!paused && n_items >= RANDOM_ITEMS / 2) begin
        drain_outputs();
        paused = 1'b1;
      end
    end

    // Let the last characters come out, then allow for stray ones.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (outstanding != 0) $error("%0d expected characters never arrived", outstanding);

    $display("Sent %0d digit requests in %0d messages, %0d of them bad codes;",
             n_items, n_msgs, n_bad);
    $display("compared %0d base64 characters under random stalls on both sides.", checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ hex_to_base64_stream_core.f @@
sv/hx64_pkg.sv
sv/hx64_if.sv
sv/hx64_front.sv
sv/hx64_queue.sv
sv/hx64_back.sv
sv/hex_to_base64_stream_core.sv
sv/hx64_checker.sv
tb/hx64_char_checker.sv
tb/tb_hex_to_base64_stream_core.sv
